### hw/rtl/vector_magnitude_limiter_macros.svh
// Assertion macros for the vector magnitude limiter.
// Included by the top level; the macros expect signals named clk and rst in scope.
`ifndef VECTOR_MAGNITUDE_LIMITER_MACROS_SVH
`define VECTOR_MAGNITUDE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VML_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vml assertion failed");

// Next-cycle implication, disabled during reset.
`define VML_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vml assertion failed");

`endif

### hw/rtl/vml_pkg.sv
// Shared types and constants for the vector magnitude limiter.
// Used by the top level, the square root pipeline and the divider pipeline.
package vml_pkg;

  localparam int RAD_W       = 64;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int NUM_W       = 64;
  localparam int QUO_W       = 32;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W;

  localparam logic [2:0] CMD_CLAMP_ACCEL = 3'd0;
  localparam logic [2:0] CMD_CLAMP_VEL   = 3'd1;
  localparam logic [2:0] CMD_MAXIMIZE    = 3'd2;
  localparam logic [2:0] CMD_SET_SPEED   = 3'd3;
  localparam logic [2:0] CMD_STEERING    = 3'd4;

  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd0;
  localparam logic [2:0] REG_VEL_LIMIT   = 3'd1;
  localparam logic [2:0] REG_PITCH_LIMIT = 3'd2;
  localparam logic [2:0] REG_ROLL_LIMIT  = 3'd3;
  localparam logic [2:0] REG_YAW_LIMIT   = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        az;
    logic [30:0]        lim;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
    logic signed [31:0] yaw;
    logic               scale;
  } side_t;

endpackage

### hw/rtl/vml_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vml_pkg for widths and the stage count.
module vml_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vml_pkg::RAD_W-1:0] rad,
  output logic [vml_pkg::ROOT_W-1:0] root
);
  import vml_pkg::*;

  logic [RAD_W-1:0]  rad_q  [0:SQRT_STAGES-1];
  logic [ROOT_W+1:0] rem_q  [0:SQRT_STAGES-1];
  logic [ROOT_W-1:0] root_q [0:SQRT_STAGES-1];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [ROOT_W+3:0] shifted;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    assign shifted = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
    assign trial   = (ROOT_W+4)'({root_in, 2'b01});
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g]  <= rad_in << 2;
        rem_q[g]  <= ge ? (ROOT_W+2)'(shifted - trial) : (ROOT_W+2)'(shifted);
        root_q[g] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

### hw/rtl/vml_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Assumes the upper half of the numerator is below the divisor. Depends on vml_pkg.
module vml_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vml_pkg::NUM_W-1:0] num,
  input  logic [vml_pkg::QUO_W-1:0] den,
  output logic [vml_pkg::QUO_W-1:0] quo
);
  import vml_pkg::*;

  logic [QUO_W-1:0] rem_q [0:DIV_STAGES-1];
  logic [QUO_W-1:0] low_q [0:DIV_STAGES-1];
  logic [QUO_W-1:0] den_q [0:DIV_STAGES-1];
  logic [QUO_W-1:0] quo_q [0:DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [QUO_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W:0]   shifted;
    logic [QUO_W:0]   den_ext;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = num[NUM_W-1:NUM_W-QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign low_in = low_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign shifted = {rem_in, low_in[QUO_W-1]};
    assign den_ext = {1'b0, den_in};
    assign ge      = shifted >= den_ext;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? QUO_W'(shifted - den_ext) : shifted[QUO_W-1:0];
        low_q[g] <= low_in << 1;
        den_q[g] <= den_in;
        quo_q[g] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

### hw/rtl/vector_magnitude_limiter.sv
// Vector magnitude limiter: clamps or rescales a Q16.16 3D vector per command.
// A request passes from acceptance to result through three front stages,
// a 32-stage square root, two scaling stages, a 32-stage divider and the output.
// Throughput is one request per cycle; a stall at the output freezes every stage.
// Synchronous reset clears the valid bits and the limit registers to zero.
// Depends on vml_pkg, vml_sqrt, vml_div and vector_magnitude_limiter_macros.svh.
`include "vector_magnitude_limiter_macros.svh"
module vector_magnitude_limiter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vec_x, vec_y, vec_z, target_speed, pitch_in, roll_in, yaw_in, one pad bit
  input  logic [223:0] s_tdata,
  // command
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z, pitch_out, roll_out, yaw_out
  output logic [191:0] m_tdata,
  // was_scaled
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import vml_pkg::*;

  logic               en;
  logic [30:0]        accel_limit;
  logic [30:0]        velocity_limit;
  logic signed [31:0] pitch_limit;
  logic signed [31:0] roll_limit;
  logic signed [31:0] yaw_limit;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit    <= '0;
      velocity_limit <= '0;
      pitch_limit    <= '0;
      roll_limit     <= '0;
      yaw_limit      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACCEL_LIMIT: accel_limit    <= cfg_wdata[30:0];
        REG_VEL_LIMIT:   velocity_limit <= cfg_wdata[30:0];
        REG_PITCH_LIMIT: pitch_limit    <= cfg_wdata;
        REG_ROLL_LIMIT:  roll_limit     <= cfg_wdata;
        REG_YAW_LIMIT:   yaw_limit      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: decode, absolute values, limit selection and angle caps.
  side_t              s1_c;
  side_t              p1;
  logic               v1;
  logic signed [31:0] in_x, in_y, in_z, in_p, in_r, in_w;
  logic               steer;

  assign in_x  = s_tdata[31:0];
  assign in_y  = s_tdata[63:32];
  assign in_z  = s_tdata[95:64];
  assign in_p  = s_tdata[158:127];
  assign in_r  = s_tdata[190:159];
  assign in_w  = s_tdata[222:191];
  assign steer = s_tuser == CMD_STEERING;

  always_comb begin
    s1_c       = '0;
    s1_c.cmd   = s_tuser;
    s1_c.vx    = in_x;
    s1_c.vy    = in_y;
    s1_c.vz    = in_z;
    s1_c.ax    = in_x[31] ? 32'(32'd0 - in_x) : in_x;
    s1_c.ay    = in_y[31] ? 32'(32'd0 - in_y) : in_y;
    s1_c.az    = in_z[31] ? 32'(32'd0 - in_z) : in_z;
    case (s_tuser)
      CMD_CLAMP_ACCEL: s1_c.lim = accel_limit;
      CMD_STEERING:    s1_c.lim = accel_limit;
      CMD_CLAMP_VEL:   s1_c.lim = velocity_limit;
      CMD_MAXIMIZE:    s1_c.lim = velocity_limit;
      CMD_SET_SPEED:   s1_c.lim = s_tdata[126:96];
      default:         s1_c.lim = '0;
    endcase
    s1_c.pitch = (steer && pitch_limit < in_p) ? pitch_limit : in_p;
    s1_c.roll  = (steer && roll_limit < in_r) ? roll_limit : in_r;
    s1_c.yaw   = (steer && yaw_limit < in_w) ? yaw_limit : in_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= s1_c;
    end
  end

  // Stage 2: squares of the components and of the limit.
  side_t       p2;
  logic        v2;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [61:0] lim_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2     <= p1;
      sq_x   <= p1.ax * p1.ax;
      sq_y   <= p1.ay * p1.ay;
      sq_z   <= p1.az * p1.az;
      lim_sq <= p1.lim * p1.lim;
    end
  end

  // Stage 3: squared magnitude and the decision to rescale.
  side_t       p3;
  side_t       p3_c;
  logic        v3;
  logic [63:0] ssum_c;
  logic [63:0] ssum;
  logic        scale_c;

  assign ssum_c = sq_x + sq_y + sq_z;

  always_comb begin
    case (p2.cmd)
      CMD_CLAMP_ACCEL: scale_c = ssum_c > 64'(lim_sq);
      CMD_CLAMP_VEL:   scale_c = ssum_c > 64'(lim_sq);
      CMD_MAXIMIZE:    scale_c = 1'b1;
      CMD_SET_SPEED:   scale_c = 1'b1;
      CMD_STEERING:    scale_c = 1'b1;
      default:         scale_c = 1'b0;
    endcase
    p3_c       = p2;
    p3_c.scale = scale_c && (ssum_c != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= p3_c;
      ssum <= ssum_c;
    end
  end

  // Square root, with the side information delayed alongside.
  logic [ROOT_W-1:0]      mag;
  side_t                  ds [1:SQRT_STAGES];
  logic [SQRT_STAGES:1]   ds_v;

  vml_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (ssum),
    .root (mag)
  );

  for (genvar g = 1; g <= SQRT_STAGES; g++) begin : g_sqrt_side
    if (g == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          ds[g] <= p3;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          ds[g] <= ds[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_v <= '0;
    end else if (en) begin
      ds_v <= {ds_v[SQRT_STAGES-1:1], v3};
    end
  end

  // Scaling stages: component times limit, then add half the magnitude for rounding.
  side_t       pm;
  logic        vm;
  logic [62:0] prod_x, prod_y, prod_z;
  logic [31:0] mag_m;
  side_t       pn;
  logic        vn;
  logic [63:0] num_x, num_y, num_z;
  logic [31:0] den_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vn <= 1'b0;
    end else if (en) begin
      vm <= ds_v[SQRT_STAGES];
      vn <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm     <= ds[SQRT_STAGES];
      prod_x <= ds[SQRT_STAGES].ax * ds[SQRT_STAGES].lim;
      prod_y <= ds[SQRT_STAGES].ay * ds[SQRT_STAGES].lim;
      prod_z <= ds[SQRT_STAGES].az * ds[SQRT_STAGES].lim;
      mag_m  <= mag;
      pn     <= pm;
      num_x  <= 64'(prod_x) + 64'(mag_m >> 1);
      num_y  <= 64'(prod_y) + 64'(mag_m >> 1);
      num_z  <= 64'(prod_z) + 64'(mag_m >> 1);
      den_n  <= mag_m;
    end
  end

  // Division, with the side information delayed alongside.
  logic [QUO_W-1:0]    quo_x, quo_y, quo_z;
  side_t               dd [1:DIV_STAGES];
  logic [DIV_STAGES:1] dd_v;

  vml_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(den_n), .quo(quo_x));
  vml_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(den_n), .quo(quo_y));
  vml_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(den_n), .quo(quo_z));

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div_side
    if (g == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          dd[g] <= pn;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          dd[g] <= dd[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dd_v <= '0;
    end else if (en) begin
      dd_v <= {dd_v[DIV_STAGES-1:1], vn};
    end
  end

  // Output register: restore signs, saturate, and choose scaled or original.
  side_t       df;
  logic [31:0] qs_x, qs_y, qs_z;
  logic [31:0] o_x, o_y, o_z;

  assign df   = dd[DIV_STAGES];
  assign qs_x = quo_x[31] ? 32'h7FFF_FFFF : quo_x;
  assign qs_y = quo_y[31] ? 32'h7FFF_FFFF : quo_y;
  assign qs_z = quo_z[31] ? 32'h7FFF_FFFF : quo_z;
  assign o_x  = !df.scale ? df.vx : (df.vx[31] ? 32'(32'd0 - qs_x) : qs_x);
  assign o_y  = !df.scale ? df.vy : (df.vy[31] ? 32'(32'd0 - qs_y) : qs_y);
  assign o_z  = !df.scale ? df.vz : (df.vz[31] ? 32'(32'd0 - qs_z) : qs_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dd_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {df.yaw, df.roll, df.pitch, o_z, o_y, o_x};
      m_tuser <= df.scale;
    end
  end

  // A rescaled vector is nonzero, so its magnitude must be at least one.
  `VML_ASSERT_IMPL(a_mag_nonzero, ds_v[SQRT_STAGES] && ds[SQRT_STAGES].scale, mag != '0)
  // Each rescaled component never exceeds the target magnitude.
  `VML_ASSERT_IMPL(a_quo_in_limit, dd_v[DIV_STAGES] && df.scale,
                   (quo_x <= 32'(df.lim)) && (quo_y <= 32'(df.lim)) && (quo_z <= 32'(df.lim)))

endmodule

### tb/tb_top.sv
// Self-checking testbench for vector_magnitude_limiter: drives commanded Q16.16 vectors,
// predicts each clamped or rescaled result and compares it field by field at the output.
// Depends on vml_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
  import vml_pkg::*;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_NONE      = 3'd7;
  localparam int         CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] vx, vy, vz;
    logic [30:0]        spd;
    logic signed [31:0] pitch, roll, yaw;
  } vec_req_t;

  typedef struct packed {
    logic [31:0] ox, oy, oz, pitch, roll, yaw;
    logic        scaled;
  } vec_res_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [223:0]  s_tdata = '0;
  logic [2:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [191:0]  m_tdata;
  logic          m_tuser;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_addr = '0;
  logic [31:0]   cfg_wdata = '0;

  // Limits as the block should hold them.
  logic [30:0]        accel_lim, vel_lim;
  logic signed [31:0] pitch_lim, roll_lim, yaw_lim;

  vec_req_t pending_reqs[$];
  vec_res_t expected_res[$];
  vec_req_t in_flight;
  int       send_idle_pct, recv_idle_pct;
  int       errors;
  int       cycles;
  logic     hold_go = 1'b0;
  int       hold_left;

  vector_magnitude_limiter dut (.*);

  always #10 clk = ~clk;

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] r, trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= s) r = trial;
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_comp(logic signed [31:0] v, logic [63:0] lim,
                                             logic [63:0] n);
    logic [63:0] mag, q;
    longint      sv;
    sv = v;
    mag = sv < 0 ? -sv : sv;
    q = (mag * lim + n / 2) / n;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return sv < 0 ? -q[31:0] : q[31:0];
  endfunction

  function automatic vec_res_t limit_vector(vec_req_t r);
    vec_res_t    res;
    logic [63:0] s, lim, n;
    longint      c[3];
    logic        sc;
    c[0] = r.vx; c[1] = r.vy; c[2] = r.vz;
    s = '0;
    lim = '0;
    sc = 1'b0;
    for (int i = 0; i < 3; i++) s += (c[i] < 0 ? -c[i] : c[i]) * (c[i] < 0 ? -c[i] : c[i]);
    if (s != 0) begin
      case (r.cmd)
        CMD_CLAMP_ACCEL: begin lim = accel_lim; sc = s > lim * lim; end
        CMD_CLAMP_VEL:   begin lim = vel_lim;   sc = s > lim * lim; end
        CMD_MAXIMIZE:    begin lim = vel_lim;   sc = 1'b1; end
        CMD_SET_SPEED:   begin lim = r.spd;     sc = 1'b1; end
        CMD_STEERING:    begin lim = accel_lim; sc = 1'b1; end
        default: ;
      endcase
    end
    if (sc) begin
      n = root_floor(s);
      res.ox = scale_comp(r.vx, lim, n);
      res.oy = scale_comp(r.vy, lim, n);
      res.oz = scale_comp(r.vz, lim, n);
    end else begin
      res.ox = r.vx; res.oy = r.vy; res.oz = r.vz;
    end
    res.pitch = r.pitch;
    res.roll  = r.roll;
    res.yaw   = r.yaw;
    if (r.cmd == CMD_STEERING) begin
      if (pitch_lim < r.pitch) res.pitch = pitch_lim;
      if (roll_lim < r.roll)   res.roll  = roll_lim;
      if (yaw_lim < r.yaw)     res.yaw   = yaw_lim;
    end
    res.scaled = sc;
    return res;
  endfunction

  // Driver: takes the next request from the pending queue once the current one is gone.
  always @(posedge clk) begin
    logic     nv;
    vec_req_t nr;
    if (!rst) begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_res.push_back(limit_vector(in_flight));
        nv = 1'b0;
      end
      if (!nv && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nr = pending_reqs.pop_front();
        in_flight <= nr;
        s_tdata <= {1'b0, nr.yaw, nr.roll, nr.pitch, nr.spd, nr.vz, nr.vy, nr.vx};
        s_tuser <= nr.cmd;
        nv = 1'b1;
      end
      s_tvalid <= nv;
    end
  end

  // Long output hold-off, counted here so that the driver keeps offering requests.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    vec_res_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          report("unexpected result", m_tdata[31:0], '0);
        end else begin
          e = expected_res.pop_front();
          if (m_tdata[31:0] !== e.ox)     report("out_x", m_tdata[31:0], e.ox);
          if (m_tdata[63:32] !== e.oy)    report("out_y", m_tdata[63:32], e.oy);
          if (m_tdata[95:64] !== e.oz)    report("out_z", m_tdata[95:64], e.oz);
          if (m_tdata[127:96] !== e.pitch)  report("pitch_out", m_tdata[127:96], e.pitch);
          if (m_tdata[159:128] !== e.roll)  report("roll_out", m_tdata[159:128], e.roll);
          if (m_tdata[191:160] !== e.yaw)   report("yaw_out", m_tdata[191:160], e.yaw);
          if (m_tuser !== e.scaled)       report("was_scaled", m_tuser, e.scaled);
        end
      end
      m_tready <= hold_left == 0 && !hold_go && $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACCEL_LIMIT: accel_lim = val[30:0];
      REG_VEL_LIMIT:   vel_lim   = val[30:0];
      REG_PITCH_LIMIT: pitch_lim = val;
      REG_ROLL_LIMIT:  roll_lim  = val;
      REG_YAW_LIMIT:   yaw_lim   = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] a, logic [31:0] v, logic [31:0] p,
                            logic [31:0] r, logic [31:0] y);
    write_reg(REG_ACCEL_LIMIT, a);
    write_reg(REG_VEL_LIMIT, v);
    write_reg(REG_PITCH_LIMIT, p);
    write_reg(REG_ROLL_LIMIT, r);
    write_reg(REG_YAW_LIMIT, y);
  endtask

  // The check waits a moment after each edge so that the driver's updates have settled.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() > 0 || expected_res.size() > 0 || s_tvalid);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      6:          return '0;
      7:          return $urandom_range(255) - 128;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  function automatic vec_req_t rand_req();
    vec_req_t r;
    int       k;
    k = $urandom_range(19);
    r.cmd = k < 18 ? 3'($urandom_range(4)) : CMD_UNUSED_LO + 3'($urandom_range(2));
    r.vx = rand_comp();
    r.vy = rand_comp();
    r.vz = rand_comp();
    if ($urandom_range(15) == 0) begin
      r.vx = '0; r.vy = '0; r.vz = '0;
    end
    case ($urandom_range(5))
      0:       r.spd = '0;
      1:       r.spd = 31'h7FFF_FFFF;
      2:       r.spd = 31'($urandom_range(32'h0010_0000));
      default: r.spd = 31'($urandom);
    endcase
    r.pitch = $urandom_range(1) ? $urandom : rand_comp();
    r.roll  = $urandom_range(1) ? $urandom : rand_comp();
    r.yaw   = $urandom_range(1) ? $urandom : rand_comp();
    return r;
  endfunction

  task automatic add_req(logic [2:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [30:0] sp, logic [31:0] p, logic [31:0] r, logic [31:0] w);
    pending_reqs.push_back('{c, x, y, z, sp, p, r, w});
  endtask

  task automatic random_phase(int count);
    repeat (count) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    accel_lim = '0; vel_lim = '0;
    pitch_lim = '0; roll_lim = '0; yaw_lim = '0;
    send_idle_pct = 10;
    recv_idle_pct = 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset limits of zero: zero vectors, scaling to a zero target, unused commands.
    for (int c = 0; c < 8; c++) add_req(3'(c), '0, '0, '0, 31'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    add_req(CMD_CLAMP_ACCEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0,
            '0, '0, '0);
    add_req(CMD_MAXIMIZE, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, '0, '0, '0, '0);
    add_req(CMD_SET_SPEED, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
            '0, '0, '0);
    add_req(CMD_STEERING, 32'h1, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_req(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 31'h1, 32'h8000_0000,
            32'h7FFF_FFFF, '0);
    drain();

    // Widest limits: magnitude within limit, overflowing vectors, speed extremes.
    set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    write_reg(REG_NONE, 32'h0000_1234);
    add_req(CMD_CLAMP_ACCEL, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, '0, '0, '0, '0);
    add_req(CMD_CLAMP_VEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0);
    add_req(CMD_CLAMP_VEL, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, '0);
    add_req(CMD_SET_SPEED, 32'h1, '0, '0, 31'h7FFF_FFFF, '0, '0, '0);
    add_req(CMD_SET_SPEED, 32'hFFFF_FFFF, 32'h1, '0, '0, '0, '0, '0);
    add_req(CMD_STEERING, 32'h8000_0000, 32'h1, 32'h1, '0,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    add_req(CMD_MAXIMIZE, 32'h0000_0003, 32'h0000_0004, '0, '0, '0, '0, '0);
    drain();

    random_phase(200);

    // Mid-range limits; the receiver holds off for a long stretch while requests keep coming.
    set_limits(32'h0005_0000, 32'h0020_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0100_0000);
    send_idle_pct = 0;
    repeat (150) pending_reqs.push_back(rand_req());
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    drain();

    send_idle_pct = 74;
    recv_idle_pct = 10;
    set_limits($urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(200);

    set_limits(32'h0000_0001, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    random_phase(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits($urandom, $urandom_range(32'h0100_0000), $urandom, $urandom, $urandom);
    random_phase(200);

    set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, $urandom, $urandom);
    random_phase(230);

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
